@@ hdl/vdp_pkg.sv @@
// Shared types, constants and the default colour table of the VGA DAC palette.
`default_nettype none

package vdp_pkg;

    // Palette geometry.
    localparam int PALETTE_ENTRIES = 256;
    localparam int DEFAULT_COLOURS = 16;
    localparam int IDX_W           = 8;
    localparam int RGB_W           = 24;
    localparam int COMP_W          = 8;

    // Decoded I/O ports.
    localparam logic [15:0] PORT_INDEX = 16'h03C8;
    localparam logic [15:0] PORT_DATA  = 16'h03C9;

    // Port reads always return zero.
    localparam logic [COMP_W-1:0] READ_DATA_IDLE = '0;
    localparam logic [COMP_W-1:0] ALPHA_OPAQUE   = 8'hFF;

    // Request opcodes.
    typedef enum logic [1:0] {
        OP_PORT_WR = 2'd0,
        OP_PORT_RD = 2'd1,
        OP_LOOKUP  = 2'd2
    } t_op;

    // Colour component selected by the component counter.
    typedef enum logic [1:0] {
        COMP_RED   = 2'd0,
        COMP_GREEN = 2'd1,
        COMP_BLUE  = 2'd2,
        COMP_DONE  = 2'd3
    } t_comp;

    // Write request into the palette memory.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [RGB_W-1:0] data;
    } t_ram_wr;

    // Reset colours of the first sixteen entries: eight basic colours, twice.
    function automatic logic [RGB_W-1:0] default_rgb(input logic [3:0] idx);
        logic [RGB_W-1:0] rgb;
        case (idx[2:0])
            3'd0:    rgb = 24'h000000;
            3'd1:    rgb = 24'h0000FF;
            3'd2:    rgb = 24'h00FF00;
            3'd3:    rgb = 24'h00FFFF;
            3'd4:    rgb = 24'hFF0000;
            3'd5:    rgb = 24'hFF00FF;
            3'd6:    rgb = 24'hFFFF00;
            default: rgb = 24'hFFFFFF;
        endcase
        return rgb;
    endfunction

endpackage

`default_nettype wire

@@ hdl/vdp_palette_ram.sv @@
// Palette memory with per-entry valid bits that stand in for the reset contents.
`default_nettype none

module vdp_palette_ram (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_rd_en,
    input  wire logic [vdp_pkg::IDX_W-1:0]   i_rd_addr,
    input  wire vdp_pkg::t_ram_wr            i_wr,
    output logic      [vdp_pkg::RGB_W-1:0]   o_rd_data
);
    import vdp_pkg::*;

    logic [RGB_W-1:0] r_mem [PALETTE_ENTRIES];
    logic             r_valid [PALETTE_ENTRIES];
    logic [RGB_W-1:0] r_rd_mem;
    logic             r_rd_valid;
    logic [RGB_W-1:0] r_rd_dflt;
    logic [RGB_W-1:0] n_rd_dflt;

    // Reset value of the entry being read.
    always_comb begin
        if ({1'b0, i_rd_addr} < (IDX_W + 1)'(DEFAULT_COLOURS)) begin
            n_rd_dflt = default_rgb(i_rd_addr[3:0]);
        end else begin
            n_rd_dflt = '0;
        end
    end

    // Memory write port.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Registered memory read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_mem  <= r_mem[i_rd_addr];
            r_rd_dflt <= n_rd_dflt;
        end
    end

    // Valid bits: an entry not yet written reads as its reset colour.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PALETTE_ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
            end
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_mem : r_rd_dflt;

endmodule

`default_nettype wire

@@ hdl/vga_dac_palette.sv @@
// Top level of the VGA DAC palette: port decode, component writes and pixel lookup.
// Every request gives its result on o_strobe after the read stage and the result registers.
// Throughput: lookups and other requests go at one per cycle; a write to the data port
// needs a read, then a merged write-back into the palette memory,
// with busy high during the write-back. The receiver cannot stall the block.
// Reset: write index and component counter clear; the palette reads its default colours
// at once, with no clearing pass.
`default_nettype none

module vga_dac_palette (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [1:0]                   i_op,
    input  wire logic [15:0]                  i_port_addr,
    input  wire logic [vdp_pkg::COMP_W-1:0]   i_port_data,
    input  wire logic [vdp_pkg::IDX_W-1:0]    i_color_index,
    output logic                              o_strobe,
    output logic      [vdp_pkg::COMP_W-1:0]   o_alpha,
    output logic      [vdp_pkg::COMP_W-1:0]   o_red,
    output logic      [vdp_pkg::COMP_W-1:0]   o_green,
    output logic      [vdp_pkg::COMP_W-1:0]   o_blue,
    output logic      [vdp_pkg::COMP_W-1:0]   o_read_data,
    output logic                              o_port_error
);
    import vdp_pkg::*;

    logic              accept;
    logic              is_index_wr;
    logic              is_data_wr;
    logic              is_lookup;
    logic              is_error;

    logic [IDX_W-1:0]  r_write_index;
    logic [1:0]        r_comp_count;
    logic [IDX_W-1:0]  n_write_index;
    logic [1:0]        n_comp_count;
    logic [IDX_W-1:0]  eff_index;
    logic [1:0]        eff_count;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [RGB_W-1:0]  rd_data;
    t_ram_wr           ram_wr;
    logic [RGB_W-1:0]  merged;

    // Write-back stage of a component write.
    logic              r_wr_pend;
    logic              r_wr_ok;
    logic [IDX_W-1:0]  r_wr_addr;
    logic [1:0]        r_wr_comp;
    logic [COMP_W-1:0] r_wr_val;

    // Read stage of every request.
    logic              r_s1_valid;
    logic              r_s1_lookup;
    logic              r_s1_err;
    logic              r_s1_opaque;

    // Result registers.
    logic              r_out_strobe;
    logic              r_out_err;
    logic [COMP_W-1:0] r_out_alpha;
    logic [COMP_W-1:0] r_out_red;
    logic [COMP_W-1:0] r_out_green;
    logic [COMP_W-1:0] r_out_blue;

    // Request decode.
    assign accept      = start && !busy;
    assign is_index_wr = (i_op == OP_PORT_WR) && (i_port_addr == PORT_INDEX);
    assign is_data_wr  = (i_op == OP_PORT_WR) && (i_port_addr == PORT_DATA);
    assign is_lookup   = (i_op == OP_LOOKUP);
    assign is_error    = ((i_op == OP_PORT_WR) && !is_index_wr && !is_data_wr)
                       || (i_op == OP_PORT_RD);

    // After three components the index steps to the next entry.
    always_comb begin
        if (r_comp_count == COMP_DONE) begin
            eff_index = r_write_index + IDX_W'(1);
            eff_count = COMP_RED;
        end else begin
            eff_index = r_write_index;
            eff_count = r_comp_count;
        end
    end

    // Next write index and component counter.
    always_comb begin
        n_write_index = r_write_index;
        n_comp_count  = r_comp_count;
        if (accept && is_index_wr) begin
            n_write_index = i_port_data;
            n_comp_count  = COMP_RED;
        end else if (accept && is_data_wr) begin
            n_write_index = eff_index;
            n_comp_count  = eff_count + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_index <= '0;
            r_comp_count  <= COMP_RED;
        end else begin
            r_write_index <= n_write_index;
            r_comp_count  <= n_comp_count;
        end
    end

    // One read port serves both the lookup and the read half of a component write.
    assign rd_en   = accept && (is_lookup || is_data_wr);
    assign rd_addr = is_lookup ? i_color_index : eff_index;

    // Replace one component of the entry read in the previous cycle.
    always_comb begin
        merged = rd_data;
        case (r_wr_comp)
            COMP_RED:   merged[23:16] = r_wr_val;
            COMP_GREEN: merged[15:8]  = r_wr_val;
            default:    merged[7:0]   = r_wr_val;
        endcase
    end

    assign ram_wr.en   = r_wr_pend && r_wr_ok;
    assign ram_wr.addr = r_wr_addr;
    assign ram_wr.data = merged;

    vdp_palette_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .i_wr      (ram_wr),
        .o_rd_data (rd_data)
    );

    // The write-back cycle holds off new requests, so no read can see a stale entry.
    assign busy = r_wr_pend;

    // Control of the write-back and read stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pend  <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_wr_pend  <= accept && is_data_wr;
            r_s1_valid <= accept;
        end
    end

    // Payload of the write-back and read stages.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_wr_ok     <= ({1'b0, eff_index} < (IDX_W + 1)'(PALETTE_ENTRIES));
            r_wr_addr   <= eff_index;
            r_wr_comp   <= eff_count;
            r_wr_val    <= {i_port_data[COMP_W-3:0], 2'b00};
            r_s1_lookup <= is_lookup
                && ({1'b0, i_color_index} < (IDX_W + 1)'(PALETTE_ENTRIES));
            r_s1_err    <= is_error;
            r_s1_opaque <= ({1'b0, i_color_index} < (IDX_W + 1)'(DEFAULT_COLOURS));
        end
    end

    // Result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_strobe <= 1'b0;
        end else begin
            r_out_strobe <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_out_err <= r_s1_err;
            if (r_s1_lookup) begin
                r_out_alpha <= r_s1_opaque ? ALPHA_OPAQUE : '0;
                r_out_red   <= rd_data[23:16];
                r_out_green <= rd_data[15:8];
                r_out_blue  <= rd_data[7:0];
            end else begin
                r_out_alpha <= '0;
                r_out_red   <= '0;
                r_out_green <= '0;
                r_out_blue  <= '0;
            end
        end
    end

    assign o_strobe     = r_out_strobe;
    assign o_port_error = r_out_err;
    assign o_alpha      = r_out_alpha;
    assign o_red        = r_out_red;
    assign o_green      = r_out_green;
    assign o_blue       = r_out_blue;
    assign o_read_data  = READ_DATA_IDLE;

`ifndef ASSERT_OFF
    // Every accepted request gives exactly one result, through the read stage and the result registers.
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##1 o_strobe)
        else $error("request without result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_s1_valid))
        else $error("result without request");

    // The write-back never stays pending back to back, and it blocks the next request.
    a_writeback_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_pend |=> !r_wr_pend)
        else $error("write-back longer than one cycle");

    a_writeback_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_pend |-> !accept && !rd_en)
        else $error("request taken during write-back");

    // Error results carry no colour.
    a_error_no_colour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_port_error) |->
            (o_alpha == '0) && (o_red == '0) && (o_green == '0) && (o_blue == '0))
        else $error("colour on an error result");
`endif

endmodule

`default_nettype wire
